/* rtl/core/dtsc_pkg.sv */
// Shared types, constants and calendar helpers for the date and time set controller.
// No dependencies; used by every module of the block through scoped names.
package dtsc_pkg;

    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned FIELD_W  = 3;

    localparam logic [YEAR_W-1:0]   MIN_YEAR_RST = 12'd1970;
    localparam logic [YEAR_W-1:0]   MAX_YEAR_RST = 12'd2099;
    localparam logic [YEAR_W-1:0]   YEAR_RST     = 12'd1970;
    localparam logic [MONTH_W-1:0]  MONTH_FIRST  = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_LAST   = 4'd12;
    localparam logic [MONTH_W-1:0]  MONTH_FEB    = 4'd2;
    localparam logic [DAY_W-1:0]    DAY_FIRST    = 5'd1;
    localparam logic [HOUR_W-1:0]   HOUR_LAST    = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST  = 6'd59;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_NEXT   = 2'd1,
        REQ_INC    = 2'd2,
        REQ_COMMIT = 2'd3
    } t_req_kind;

    typedef enum logic [FIELD_W-1:0] {
        FLD_YEAR   = 3'd0,
        FLD_MONTH  = 3'd1,
        FLD_DAY    = 3'd2,
        FLD_HOUR   = 3'd3,
        FLD_MINUTE = 3'd4
    } t_field;

    typedef enum logic {
        CFG_MIN_YEAR = 1'b0,
        CFG_MAX_YEAR = 1'b1
    } t_cfg_addr;

    typedef struct packed {
        logic [YEAR_W-1:0] min_year;
        logic [YEAR_W-1:0] max_year;
    } t_year_cfg;

    typedef struct packed {
        t_req_kind           kind;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } t_req;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        t_field              sel;
        logic                write_clock;
    } t_result;

    // true when q is a multiple of 25 (q < 1024): parallel compares against constants
    function automatic logic is_mult25(input logic [9:0] q);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k <= 40; k++) begin
            if (q == 10'(k * 25)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Gregorian rule on the raw 12-bit year; year 0 counts as leap
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic by100;
        logic by400;
        by100 = (y[1:0] == 2'd0) && is_mult25(y[11:2]);
        by400 = (y[3:0] == 4'd0) && is_mult25({2'b00, y[11:4]});
        return ((y[1:0] == 2'd0) && !by100) || by400;
    endfunction

    // month outside 1..12 reads as January
    function automatic logic [DAY_W-1:0] days_in(input logic [YEAR_W-1:0] y,
                                                  input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:                  n = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:               n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

/* rtl/core/dtsc_cfg_regs.sv */
// Year range registers written through the configuration channel.
// Depends on dtsc_pkg.
module dtsc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_addr,
    input  logic [dtsc_pkg::YEAR_W-1:0]   i_cfg_data,
    output dtsc_pkg::t_year_cfg           o_cfg
);

    dtsc_pkg::t_year_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_year <= dtsc_pkg::MIN_YEAR_RST;
            r_cfg.max_year <= dtsc_pkg::MAX_YEAR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                dtsc_pkg::CFG_MIN_YEAR: r_cfg.min_year <= i_cfg_data;
                dtsc_pkg::CFG_MAX_YEAR: r_cfg.max_year <= i_cfg_data;
                default:                ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/dtsc_update.sv */
// Date/time state registers and the per-request next-state logic.
// Depends on dtsc_pkg.
module dtsc_update (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  dtsc_pkg::t_req       i_req,
    input  dtsc_pkg::t_year_cfg  i_cfg,
    output dtsc_pkg::t_result    o_res
);

    logic [dtsc_pkg::YEAR_W-1:0]   r_year,   n_year;
    logic [dtsc_pkg::MONTH_W-1:0]  r_month,  n_month;
    logic [dtsc_pkg::DAY_W-1:0]    r_day,    n_day;
    logic [dtsc_pkg::HOUR_W-1:0]   r_hour,   n_hour;
    logic [dtsc_pkg::MINUTE_W-1:0] r_minute, n_minute;
    dtsc_pkg::t_field              r_sel,    n_sel;

    logic [dtsc_pkg::YEAR_W:0]     year_inc;
    logic [dtsc_pkg::DAY_W-1:0]    day_lim;
    logic [dtsc_pkg::DAY_W-1:0]    day_raw;
    logic                          clamp;
    logic                          wr;

    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_sel    = r_sel;
        clamp    = 1'b0;
        wr       = 1'b0;
        year_inc = {1'b0, r_year} + 13'd1;
        day_raw  = r_day;

        case (i_req.kind)
            dtsc_pkg::REQ_LOAD: begin
                n_year = i_req.year;
                if (i_req.month == 4'd0) begin
                    n_month = dtsc_pkg::MONTH_FIRST;
                end else if (i_req.month > dtsc_pkg::MONTH_LAST) begin
                    n_month = dtsc_pkg::MONTH_LAST;
                end else begin
                    n_month = i_req.month;
                end
                day_raw  = (i_req.day == 5'd0) ? dtsc_pkg::DAY_FIRST : i_req.day;
                n_hour   = (i_req.hour > dtsc_pkg::HOUR_LAST) ? dtsc_pkg::HOUR_LAST
                                                              : i_req.hour;
                n_minute = (i_req.minute > dtsc_pkg::MINUTE_LAST) ? dtsc_pkg::MINUTE_LAST
                                                                  : i_req.minute;
                n_sel    = dtsc_pkg::FLD_YEAR;
                clamp    = 1'b1;
            end
            dtsc_pkg::REQ_NEXT: begin
                n_sel = (r_sel == dtsc_pkg::FLD_MINUTE)
                        ? dtsc_pkg::FLD_YEAR
                        : dtsc_pkg::t_field'(r_sel + 3'd1);
            end
            dtsc_pkg::REQ_INC: begin
                case (r_sel)
                    dtsc_pkg::FLD_YEAR: begin
                        n_year = (year_inc > {1'b0, i_cfg.max_year})
                                 ? i_cfg.min_year : year_inc[dtsc_pkg::YEAR_W-1:0];
                        clamp  = 1'b1;
                    end
                    dtsc_pkg::FLD_MONTH: begin
                        n_month = (r_month >= dtsc_pkg::MONTH_LAST)
                                  ? dtsc_pkg::MONTH_FIRST : r_month + 4'd1;
                        clamp   = 1'b1;
                    end
                    dtsc_pkg::FLD_DAY: begin
                        n_day = (r_day >= dtsc_pkg::days_in(r_year, r_month))
                                ? dtsc_pkg::DAY_FIRST : r_day + 5'd1;
                    end
                    dtsc_pkg::FLD_HOUR: begin
                        n_hour = (r_hour >= dtsc_pkg::HOUR_LAST) ? 5'd0 : r_hour + 5'd1;
                    end
                    default: begin
                        n_minute = (r_minute >= dtsc_pkg::MINUTE_LAST)
                                   ? 6'd0 : r_minute + 6'd1;
                    end
                endcase
            end
            default: begin
                wr = 1'b1;
            end
        endcase

        // day clamp after a load or a year/month change
        day_lim = dtsc_pkg::days_in(n_year, n_month);
        if (clamp) begin
            n_day = (day_raw > day_lim) ? day_lim : day_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year   <= dtsc_pkg::YEAR_RST;
            r_month  <= dtsc_pkg::MONTH_FIRST;
            r_day    <= dtsc_pkg::DAY_FIRST;
            r_hour   <= 5'd0;
            r_minute <= 6'd0;
            r_sel    <= dtsc_pkg::FLD_YEAR;
        end else if (i_step) begin
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_sel    <= n_sel;
        end
    end

    assign o_res.year        = n_year;
    assign o_res.month       = n_month;
    assign o_res.day         = n_day;
    assign o_res.hour        = n_hour;
    assign o_res.minute      = n_minute;
    assign o_res.sel         = n_sel;
    assign o_res.write_clock = wr;

endmodule

/* rtl/core/date_time_set_controller_top.sv */
// Top level of the date and time set controller: input register, result register.
// Depends on dtsc_pkg, dtsc_cfg_regs and dtsc_update.
//
// Usage:
//  - Requests arrive on the s_axis channel: tuser carries the request kind
//    (load, next field, increment, commit), tdata the clock time used by load.
//  - Each request gives exactly one item on m_axis: the time being set, the
//    selected field and, on commit, the write_clock flag.
//  - The year wrap range is written on the cfg channel (index 0 min_year,
//    index 1 max_year); cfg is always ready, write it while the block is idle.
// Timing:
//  - From acceptance an item waits in the input register, then passes through
//    the update logic into the result register that drives m_axis_tvalid.
//  - Throughput is one item per cycle while m_axis_tready is high; the state
//    update is one pass of wrap/clamp logic, so requests chain via the state regs.
// Reset (i_rst_n low, synchronous): 1970-01-01 00:00, year selected, year
//  range 1970..2099, both pipeline stages emptied.
// Stall: while m_axis_tready is low the result register holds; the input
//  register still takes one more item, then s_axis_tready drops.
module date_time_set_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // load_year[11:0] load_month[15:12] load_day[20:16]
                                       // load_hour[25:21] load_minute[31:26]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_year[11:0] out_month[15:12] out_day[20:16]
                                       // out_hour[25:21] out_minute[31:26]
    output logic [3:0]  m_axis_tuser,  // selected_field[2:0] write_clock[3]
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_addr,
    input  logic [11:0] i_cfg_data
);

    dtsc_pkg::t_year_cfg cfg;
    dtsc_pkg::t_req      r_in;
    logic                r_in_valid;
    dtsc_pkg::t_result   res;
    dtsc_pkg::t_result   r_out;
    logic                r_out_valid;
    logic                step;
    logic                take_in;

    assign o_cfg_ready = 1'b1;

    dtsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // item moves from the input register into the result register
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= take_in || (r_in_valid && !step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in.kind   <= dtsc_pkg::t_req_kind'(s_axis_tuser);
            r_in.year   <= s_axis_tdata[11:0];
            r_in.month  <= s_axis_tdata[15:12];
            r_in.day    <= s_axis_tdata[20:16];
            r_in.hour   <= s_axis_tdata[25:21];
            r_in.minute <= s_axis_tdata[31:26];
        end
    end

    dtsc_update u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= step || (r_out_valid && !m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.minute, r_out.hour, r_out.day, r_out.month, r_out.year};
    assign m_axis_tuser  = {r_out.write_clock, r_out.sel};

endmodule
